/* hdl/sfcd_pkg.sv */
// Package for the sensor frame CRC decoder: frame and result types,
// protocol constants and the CRC-8 byte step. No dependencies.
package sfcd_pkg;

  localparam logic [7:0] CRC_POLY    = 8'h31;
  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_MSB     = 8'h80;
  localparam logic [7:0] STATUS_MASK = 8'h98;
  localparam logic [7:0] STATUS_WANT = 8'h18;

  // Byte positions inside a reply frame
  localparam logic [2:0] BYTE_STATUS   = 3'd0;
  localparam logic [2:0] BYTE_HUM_HI   = 3'd1;
  localparam logic [2:0] BYTE_HUM_MID  = 3'd2;
  localparam logic [2:0] BYTE_SPLIT    = 3'd3;
  localparam logic [2:0] BYTE_TEMP_MID = 3'd4;
  localparam logic [2:0] BYTE_TEMP_LO  = 3'd5;
  localparam logic [2:0] BYTE_CRC      = 3'd6;

  // Scaling: value = (raw * scale) >> 20, temperature minus offset
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;

  typedef struct packed {
    logic [19:0] hum_raw;
    logic [19:0] temp_raw;
    logic        check_ok;
    logic        bus_err;
  } frame_t;

  typedef struct packed {
    logic [13:0]        humidity;
    logic signed [14:0] temperature;
    logic               accepted;
    logic               failed;
  } result_t;

  // One CRC-8 byte, MSB first
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/sfcd_fifo.sv */
// Small register queue with count output.
// Generic; used for frame records and for results. Depends on nothing.
module sfcd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           full,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* hdl/sfcd_front.sv */
// Front end: byte counter, running CRC-8 and raw field assembly.
// Emits one frame record per seventh byte. Uses sfcd_pkg.
module sfcd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                bus_error,
  output logic                frm_push,
  output sfcd_pkg::frame_t    frm
);

  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [19:0] hum_r, hum_nxt;
  logic [19:0] temp_r, temp_nxt;
  logic        err_now;
  logic        frame_end;

  assign err_now   = err_r | bus_error;
  assign frame_end = (cnt_r >= sfcd_pkg::BYTE_CRC);

  always_comb begin
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    err_nxt    = err_r;
    status_nxt = status_r;
    hum_nxt    = hum_r;
    temp_nxt   = temp_r;
    if (take) begin
      if (frame_end) begin
        cnt_nxt = sfcd_pkg::BYTE_STATUS;
        crc_nxt = sfcd_pkg::CRC_INIT;
        err_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 3'd1;
        crc_nxt = sfcd_pkg::crc8_step(crc_r, data_byte);
        err_nxt = err_now;
        case (cnt_r)
          sfcd_pkg::BYTE_STATUS:   status_nxt = data_byte;
          sfcd_pkg::BYTE_HUM_HI:   hum_nxt[19:12] = data_byte;
          sfcd_pkg::BYTE_HUM_MID:  hum_nxt[11:4] = data_byte;
          sfcd_pkg::BYTE_SPLIT: begin
            hum_nxt[3:0]    = data_byte[7:4];
            temp_nxt[19:16] = data_byte[3:0];
          end
          sfcd_pkg::BYTE_TEMP_MID: temp_nxt[15:8] = data_byte;
          sfcd_pkg::BYTE_TEMP_LO:  temp_nxt[7:0] = data_byte;
          default: ;
        endcase
      end
    end
  end

  assign frm_push      = take && frame_end;
  assign frm.hum_raw   = hum_r;
  assign frm.temp_raw  = temp_r;
  assign frm.check_ok  = (crc_r == data_byte) &&
                         ((status_r & sfcd_pkg::STATUS_MASK) == sfcd_pkg::STATUS_WANT);
  assign frm.bus_err   = err_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= sfcd_pkg::BYTE_STATUS;
      crc_r <= sfcd_pkg::CRC_INIT;
      err_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    hum_r    <= hum_nxt;
    temp_r   <= temp_nxt;
  end

endmodule

/* hdl/sfcd_back.sv */
// Back end: scales raw values (registered multiply, then shift/offset)
// and holds the last reported values. Uses sfcd_pkg.
module sfcd_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            frm_valid,
  input  sfcd_pkg::frame_t                frm,
  output logic                            frm_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
  output logic                            res_push,
  output sfcd_pkg::result_t               res
);

  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam logic [CW:0] DEPTH_C = (CW + 1)'(OUT_DEPTH);

  logic               s1_v_r;
  logic [33:0]        hum_prod_r;
  logic [34:0]        temp_prod_r;
  logic               ok_r;
  logic               err_r;
  logic [13:0]        last_hum_r, last_hum_nxt;
  logic signed [14:0] last_temp_r, last_temp_nxt;
  logic [13:0]        hum_new;
  logic [14:0]        temp_new;
  logic [CW:0]        committed;

  // Reserve a result slot for the frame in flight
  assign committed = {1'b0, out_count} + (CW + 1)'(s1_v_r);
  assign frm_pop   = frm_valid && (committed < DEPTH_C);

  assign hum_new  = hum_prod_r[33:20];
  assign temp_new = temp_prod_r[34:20] - sfcd_pkg::TEMP_OFFSET;

  always_comb begin
    last_hum_nxt  = last_hum_r;
    last_temp_nxt = last_temp_r;
    res.accepted  = 1'b0;
    res.failed    = 1'b0;
    if (s1_v_r) begin
      if (err_r) begin
        last_hum_nxt  = '0;
        last_temp_nxt = '0;
        res.failed    = 1'b1;
      end else if (ok_r) begin
        last_hum_nxt  = hum_new;
        last_temp_nxt = $signed(temp_new);
        res.accepted  = 1'b1;
      end
    end
    res.humidity    = last_hum_nxt;
    res.temperature = last_temp_nxt;
  end

  assign res_push = s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      last_hum_r  <= '0;
      last_temp_r <= '0;
    end else begin
      s1_v_r      <= frm_pop;
      last_hum_r  <= last_hum_nxt;
      last_temp_r <= last_temp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_pop) begin
      hum_prod_r  <= {14'd0, frm.hum_raw} * {20'd0, sfcd_pkg::HUM_SCALE};
      temp_prod_r <= {15'd0, frm.temp_raw} * {20'd0, sfcd_pkg::TEMP_SCALE};
      ok_r        <= frm.check_ok;
      err_r       <= frm.bus_err;
    end
  end

endmodule

/* hdl/sensor_frame_crc_decode_top.sv */
// Top level of the sensor reply frame decoder.
// Instantiates sfcd_front, sfcd_fifo (twice) and sfcd_back; uses sfcd_pkg.
//
// Usage:
//   Input side is a queue write port: a byte beat is taken on a rising edge
//   with in_push high and in_full low. Seven beats make a frame: status,
//   five data bytes, received CRC. in_bus_error on any beat marks the frame
//   as failed.
//   Result side is a queue read port: while out_empty is low the oldest
//   result sits on the out_ ports; a beat leaves on an edge with out_pop
//   high. One result per frame, none for the other six bytes.
// Throughput: one byte beat per cycle while in_full is low. The front end does one
//   unrolled CRC-8 step and a field write per byte.
// Path: after the CRC beat is taken, the frame record passes the frame queue,
//   then one registered multiply stage in the back end, then the result queue.
// Stall: if out_pop stays low, results pile up in the result queue
//   (OUT_DEPTH deep); the back end then stops draining the frame queue
//   (FRAME_DEPTH deep), and once that fills in_full rises. Since a frame
//   needs seven beats, a stalled reader blocks input only after several
//   frames.
// Reset: synchronous, active low; clears byte counter, CRC, error flag,
//   last values and both queues. Usable the cycle after reset drops.
module sensor_frame_crc_decode_top #(
  parameter int FRAME_DEPTH = 2,
  parameter int OUT_DEPTH   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_bus_error,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [13:0]        out_humidity_centi,
  output logic signed [14:0] out_temperature_centi,
  output logic               out_frame_accepted,
  output logic               out_frame_failed
);

  localparam int FW = $bits(sfcd_pkg::frame_t);
  localparam int RW = $bits(sfcd_pkg::result_t);

  sfcd_pkg::frame_t               frm_in, frm_out;
  sfcd_pkg::result_t              res_in, res_out;
  logic                           frm_push, frm_pop, frm_full, frm_empty;
  logic [$clog2(FRAME_DEPTH+1)-1:0] frm_count;
  logic                           res_push, res_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] res_count;
  logic                           take;

  // Stall all bytes while the frame queue is full; keeps the front simple
  assign in_full = frm_full;
  assign take    = in_push && !frm_full;

  sfcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .bus_error (in_bus_error),
    .frm_push  (frm_push),
    .frm       (frm_in)
  );

  sfcd_fifo #(.WIDTH(FW), .DEPTH(FRAME_DEPTH)) u_frm_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (frm_push),
    .wdata (frm_in),
    .pop   (frm_pop),
    .rdata (frm_out),
    .full  (frm_full),
    .empty (frm_empty),
    .count (frm_count)
  );

  sfcd_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (!frm_empty && (frm_count != '0)),
    .frm       (frm_out),
    .frm_pop   (frm_pop),
    .out_count (res_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Back end reserves a slot before pushing, so res_full never blocks a push
  sfcd_fifo #(.WIDTH(RW), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .pop   (out_pop && !res_full | out_pop),
    .rdata (res_out),
    .full  (res_full),
    .empty (out_empty),
    .count (res_count)
  );

  assign out_humidity_centi    = res_out.humidity;
  assign out_temperature_centi = res_out.temperature;
  assign out_frame_accepted    = res_out.accepted;
  assign out_frame_failed      = res_out.failed;

endmodule

/* hdl/sfcd_checker.sv */
// Port-level checker for sensor_frame_crc_decode_top, with its bind.
// Sees only the top-level ports; no package dependency.
module sfcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic [13:0]        out_humidity_centi,
  input logic signed [14:0] out_temperature_centi,
  input logic               out_frame_accepted,
  input logic               out_frame_failed
);

  // Both flags never set on one result
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_frame_accepted && out_frame_failed))
    else $error("accepted and failed both set");

  // A failed frame reports zeros
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_failed) |->
      (out_humidity_centi == 14'd0 && out_temperature_centi == 15'sd0))
    else $error("failed frame with nonzero values");

  // Humidity stays below 100.00 %
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_humidity_centi <= 14'd9999))
    else $error("humidity out of range");

  // Temperature stays within -50.00 .. 149.99 C
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_temperature_centi >= -15'sd5000 &&
                    out_temperature_centi <= 15'sd14999))
    else $error("temperature out of range");

  // A stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_humidity_centi) && $stable(out_temperature_centi)))
    else $error("result changed while stalled");

endmodule

bind sensor_frame_crc_decode_top sfcd_checker u_sfcd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_empty             (out_empty),
  .out_pop               (out_pop),
  .out_humidity_centi    (out_humidity_centi),
  .out_temperature_centi (out_temperature_centi),
  .out_frame_accepted    (out_frame_accepted),
  .out_frame_failed      (out_frame_failed)
);

/* dv/tb_sensor_frame_crc_decode_top.sv */
// Self-checking bench for sensor_frame_crc_decode_top: byte beats in, decoded readings out.
// A directed frame table, then random frames, are checked against an in-bench frame decoder.
// Depends on sfcd_pkg (constants, result_t) and the RTL top level only.
module tb_sensor_frame_crc_decode_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1350;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // How the data byte of a table row is formed
  typedef enum logic [1:0] {
    BYTE_AS_IS,      // byte taken as written
    BYTE_CRC_GOOD,   // byte replaced by the CRC of the bytes so far
    BYTE_CRC_BAD     // byte replaced by the inverted CRC
  } byte_src_t;

  typedef struct {
    logic [7:0]        data;
    logic              bus_err;
    byte_src_t         src;
    logic              typed;     // use the hand-written reading below
    sfcd_pkg::result_t reading;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_bus_error = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [13:0]        out_humidity_centi;
  logic signed [14:0] out_temperature_centi;
  logic               out_frame_accepted;
  logic               out_frame_failed;

  sensor_frame_crc_decode_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_data_byte         (in_data_byte),
    .in_bus_error         (in_bus_error),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_humidity_centi   (out_humidity_centi),
    .out_temperature_centi(out_temperature_centi),
    .out_frame_accepted   (out_frame_accepted),
    .out_frame_failed     (out_frame_failed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame decoder state: mirrors the block's byte counter, running CRC,
  // assembled raw values and the last reported reading. Reset only once.
  // ---------------------------------------------------------------------------
  logic [2:0]         frame_pos    = 3'd0;
  logic [7:0]         frame_crc    = sfcd_pkg::CRC_INIT;
  logic [7:0]         frame_status = 8'h00;
  logic [19:0]        hum_acc      = 20'h0;
  logic [19:0]        temp_acc     = 20'h0;
  logic               frame_err    = 1'b0;
  logic [13:0]        held_hum     = 14'd0;
  logic signed [14:0] held_temp    = 15'sd0;

  sfcd_pkg::result_t pending_readings[$];   // readings owed by the block, oldest first

  int err_count       = 0;
  int beats_sent      = 0;
  int readings_seen   = 0;
  int frames_ok       = 0;
  int frames_bus_fail = 0;
  int frames_rejected = 0;
  int cycles          = 0;
  bit push_steady     = 1'b0;
  bit pop_steady      = 1'b0;
  int pop_hold        = 0;

  // CRC-8, poly 0x31, MSB first, one input bit per round
  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ sfcd_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  // Advance the decoder by one accepted byte; on the CRC byte a reading is due
  task automatic decode_beat(input logic [7:0] b, input logic e,
                             output logic due, output sfcd_pkg::result_t r);
    logic [33:0] hum_prod;
    logic [34:0] temp_prod;
    due = 1'b0;
    r   = '0;
    frame_err = frame_err | e;
    if (frame_pos < sfcd_pkg::BYTE_CRC) begin
      frame_crc = crc8_next(frame_crc, b);
      case (frame_pos)
        sfcd_pkg::BYTE_STATUS:   frame_status = b;
        sfcd_pkg::BYTE_HUM_HI:   hum_acc = {b, 12'h000};
        sfcd_pkg::BYTE_HUM_MID:  hum_acc[11:4] = b;
        sfcd_pkg::BYTE_SPLIT: begin
          hum_acc[3:0] = b[7:4];
          temp_acc     = {b[3:0], 16'h0000};
        end
        sfcd_pkg::BYTE_TEMP_MID: temp_acc[15:8] = b;
        default:                 temp_acc[7:0] = b;
      endcase
      frame_pos = frame_pos + 3'd1;
    end else begin
      if (frame_err) begin
        held_hum  = '0;
        held_temp = '0;
        r.failed  = 1'b1;
      end else if (frame_crc == b &&
                   (frame_status & sfcd_pkg::STATUS_MASK) == sfcd_pkg::STATUS_WANT) begin
        hum_prod   = hum_acc * sfcd_pkg::HUM_SCALE;
        temp_prod  = temp_acc * sfcd_pkg::TEMP_SCALE;
        held_hum   = hum_prod[33:20];
        held_temp  = temp_prod[34:20] - sfcd_pkg::TEMP_OFFSET;
        r.accepted = 1'b1;
      end
      frame_pos     = 3'd0;
      frame_crc     = sfcd_pkg::CRC_INIT;
      frame_err     = 1'b0;
      r.humidity    = held_hum;
      r.temperature = held_temp;
      due           = 1'b1;
    end
  endtask

  // Idle length: mostly none, some short, a few long
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= REPORT_MAX) begin
      $display("[%0t] ERROR %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver. push stays high across back-to-back beats; it is lowered
  // only when a gap follows, so it never sees two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = push_steady ? 0 : pause_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_bus_error <= e;
    do @(posedge clk); while (in_full);
    beats_sent++;
  endtask

  // One beat end to end: drive it, then log what the block now owes
  task automatic feed(input logic [7:0] b, input logic e,
                      input logic typed, input sfcd_pkg::result_t typed_reading);
    logic              due;
    sfcd_pkg::result_t r;
    send_byte(b, e);
    decode_beat(b, e, due, r);
    if (due) begin
      pending_readings.push_back(typed ? typed_reading : r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random frames: mostly well-formed with random content, the rest noise.
  // Frames realign on every seventh beat, so any bytes make a frame.
  // ---------------------------------------------------------------------------
  task automatic random_frame();
    logic [7:0] b;
    logic [7:0] status;
    logic       e;
    int         err_at;
    int         fill;
    int         crc_pick;
    bit         noise;
    push_steady = ($urandom_range(0, 3) == 0);
    noise       = ($urandom_range(0, 99) < 15);
    status = 8'($urandom_range(0, 255));
    if (!noise && $urandom_range(0, 99) < 70) begin
      status = (status & ~sfcd_pkg::STATUS_MASK) | sfcd_pkg::STATUS_WANT;
    end
    fill     = $urandom_range(0, 9);             // 0: all zero, 1: all ones
    err_at   = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 6) : 7;
    crc_pick = $urandom_range(0, 99);
    for (int i = 0; i < 7; i++) begin
      e = (i == err_at) || ($urandom_range(0, 99) == 0);
      if (noise) begin
        b = 8'($urandom_range(0, 255));
        e = ($urandom_range(0, 9) == 0);
      end else if (i == 0) begin
        b = status;
      end else if (i < 6) begin
        b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      end else if (crc_pick < 75) begin
        b = frame_crc;
      end else if (crc_pick < 95) begin
        b = frame_crc ^ 8'($urandom_range(1, 255));
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      feed(b, e, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each popped reading, then pick the next pop level.
  // Occasional steady stretches pop every cycle.
  // ---------------------------------------------------------------------------
  task automatic check_reading();
    sfcd_pkg::result_t want;
    sfcd_pkg::result_t seen;
    seen = '{out_humidity_centi, out_temperature_centi,
             out_frame_accepted, out_frame_failed};
    readings_seen++;
    if (seen.accepted) frames_ok++;
    else if (seen.failed) frames_bus_fail++;
    else frames_rejected++;
    if (pending_readings.size() == 0) begin
      note_error($sformatf("unexpected reading hum=%0d temp=%0d acc=%0b fail=%0b",
                           seen.humidity, seen.temperature, seen.accepted, seen.failed));
    end else begin
      want = pending_readings.pop_front();
      if (seen.humidity !== want.humidity || seen.temperature !== want.temperature ||
          seen.accepted !== want.accepted || seen.failed !== want.failed) begin
        note_error($sformatf(
          "reading %0d: exp hum=%0d temp=%0d acc=%0b fail=%0b, got hum=%0d temp=%0d acc=%0b fail=%0b",
          readings_seen, want.humidity, want.temperature, want.accepted, want.failed,
          seen.humidity, seen.temperature, seen.accepted, seen.failed));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        check_reading();
      end
      if ($urandom_range(0, 199) == 0) begin
        pop_steady = !pop_steady;
      end
      if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold = pop_hold - 1;
      end else begin
        out_pop <= 1'b1;
        pop_hold = pop_steady ? 0 : pause_len();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Readings are typed in where they are plain from the
  // scaling: raw zero and raw full scale, a bad CRC that keeps the last
  // reading, and a bus error that clears it.
  // ---------------------------------------------------------------------------
  script_row_t script[$];

  task automatic row(input logic [7:0] b, input logic e, input byte_src_t src,
                     input logic typed, input logic [13:0] h,
                     input logic signed [14:0] t, input logic a, input logic f);
    script_row_t sr;
    sr.data    = b;
    sr.bus_err = e;
    sr.src     = src;
    sr.typed   = typed;
    sr.reading = '{h, t, a, f};
    script.push_back(sr);
  endtask

  initial begin
    logic [7:0] b;

    //  data   err   source          typed hum    temp        acc   fail
    // raw zero on both channels: lowest humidity and temperature
    row(8'h18, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h00, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h00, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h00, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h00, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h00, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h00, 1'b0, BYTE_CRC_GOOD, 1'b1, 14'd0, -15'sd5000, 1'b1, 1'b0);
    // full-scale raw, status with every don't-care bit set
    row(8'h7F, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'hFF, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'hFF, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'hFF, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'hFF, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'hFF, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h00, 1'b0, BYTE_CRC_GOOD, 1'b1, 14'd9999, 15'sd14999, 1'b1, 1'b0);
    // CRC mismatch: last reading is repeated, no flags
    row(8'h18, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h12, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h34, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h56, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h78, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h9A, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h00, 1'b0, BYTE_CRC_BAD,  1'b1, 14'd9999, 15'sd14999, 1'b0, 1'b0);
    // bus error on the CRC beat itself, otherwise a clean frame: values cleared
    row(8'h18, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'hA5, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h5A, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'hC3, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h3C, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h81, 1'b0, BYTE_AS_IS,    1'b0, 14'd0, 15'sd0,     1'b0, 1'b0);
    row(8'h00, 1'b1, BYTE_CRC_GOOD, 1'b1, 14'd0, 15'sd0,     1'b0, 1'b1);

    // reset: held low, then released and left to settle before the first beat
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      case (script[i].src)
        BYTE_CRC_GOOD: b = frame_crc;
        BYTE_CRC_BAD:  b = ~frame_crc;
        default:       b = script[i].data;
      endcase
      feed(b, script[i].bus_err, script[i].typed, script[i].reading);
    end

    while (beats_sent < script.size() + RANDOM_BEATS) begin
      random_frame();
    end
    in_push <= 1'b0;

    // drain: the watchdog covers a block that never delivers
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d byte beats, %0d readings checked", beats_sent, readings_seen);
    $display("Frames: %0d accepted, %0d bus failures, %0d rejected by CRC or status",
             frames_ok, frames_bus_fail, frames_rejected);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/sfcd_pkg.sv
hdl/sfcd_fifo.sv
hdl/sfcd_front.sv
hdl/sfcd_back.sv
hdl/sensor_frame_crc_decode_top.sv
hdl/sfcd_checker.sv
dv/tb_sensor_frame_crc_decode_top.sv
